// ===== src/srsw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, codes and constants of the selective-repeat sender window.
// No dependencies; every other file of the block imports this package.
package srsw_pkg;

    // Fixed field widths.
    localparam int SEQ_W         = 8;
    localparam int DATA_W        = 32;
    localparam int MAX_SEQ_BITS  = 8;
    localparam int MAX_WIN_BITS  = 6;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_WINDOW   = 16;
    localparam int DEF_PAYLOAD_BITS = 32;

    // Configuration register indexes and reset values.
    localparam logic       CFG_WINDOW_BITS = 1'b0;
    localparam logic       CFG_SEQ_BITS    = 1'b1;
    localparam logic [2:0] RST_WINDOW_BITS = 3'd2;
    localparam logic [3:0] RST_SEQ_BITS    = 4'd8;

    typedef enum logic [1:0] {
        OP_SEND    = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_UNUSED  = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        EV_REFUSED = 3'd0,
        EV_SENT    = 3'd1,
        EV_ACKED   = 3'd2,
        EV_OUTSIDE = 3'd3,
        EV_CORRUPT = 3'd4,
        EV_RESENT  = 3'd5
    } event_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SLIDE,
        ST_HOLD
    } state_t;

    // Per-item result apart from the window status fields.
    typedef struct packed {
        event_t              event_res;
        logic                tx_valid;
        logic [SEQ_W-1:0]    tx_seq;
        logic [DATA_W-1:0]   tx_payload;
        logic                timer_start;
        logic                timer_stop;
        logic [SEQ_W-1:0]    timer_seq;
    } res_t;

endpackage

// ===== src/srsw_payload_mem.sv =====
`timescale 1ns / 1ps
// Payload store: one write port and one registered read port.
// Depends on srsw_pkg for the default depth and width.
module srsw_payload_mem
    import srsw_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_WINDOW,
    parameter int WIDTH  = DEF_PAYLOAD_BITS,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/srsw_ack_marks.sv =====
`timescale 1ns / 1ps
// Acknowledged marks, one flip-flop per slot, cleared by reset.
// Depends on srsw_pkg for the default window depth.
module srsw_ack_marks
    import srsw_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_WINDOW,
    parameter int ADDR_W = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              set_en,
    input  logic [ADDR_W-1:0] set_idx,
    input  logic              clr_en,
    input  logic [ADDR_W-1:0] clr_idx,
    input  logic [ADDR_W-1:0] rd_idx,
    output logic              rd_bit
);

    logic [DEPTH-1:0] marks_reg;
    logic [DEPTH-1:0] marks_next;

    always_comb
    begin
        marks_next = marks_reg;
        if (set_en)
        begin
            marks_next[set_idx] = 1'b1;
        end
        if (clr_en)
        begin
            marks_next[clr_idx] = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marks_reg <= '0;
        end
        else
        begin
            marks_reg <= marks_next;
        end
    end

    assign rd_bit = marks_reg[rd_idx];

endmodule

// ===== src/selective_repeat_sender_window_unit.sv =====
`timescale 1ns / 1ps
// Top level of the selective-repeat ARQ sender window: sequencer, window
// counters and output register. Uses srsw_pkg, srsw_payload_mem, srsw_ack_marks.
//
// Channel   Direction  Signals                      Contents
// s_*       in         s_tvalid/s_tready/s_tdata/   one command transaction
//                      s_tuser
// m_*       out        m_tvalid/m_tready/m_tdata/   one result transaction
//                      m_tuser
// cfg_*     in         cfg_wr_en/cfg_addr/cfg_wdata register writes, no wait
//
// A transaction is accepted in the idle state and executed in the following
// cycle. The payload memory read issued at acceptance is ready in that
// execute cycle. An ACK equal to the base then walks the acked marks one
// slot per cycle, up to a full window.
// Reset clears the sequencer, the window counters and the acked marks at
// once; the payload memory is not cleared. A single result register parts
// the two sides: while it waits on m_tready the next transaction is still
// accepted and executed, and the block holds it until the register frees.
module selective_repeat_sender_window_unit
    import srsw_pkg::*;
#(
    parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // payload[31:0], seq_num[39:32], checksum_ok[40], zero pad
    input  logic [1:0]  s_tuser,   // operation[1:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // tx_valid[0], tx_seq[8:1], tx_payload[40:9],
                                   // timer_start[41], timer_stop[42], timer_seq[50:43],
                                   // window_base[58:51], next_seq[66:59],
                                   // window_full[67], zero pad
    output logic [2:0]  m_tuser,   // event_res[2:0]

    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [3:0]  cfg_wdata
);

    // Largest window exponent that fits the slot store, and the widths that
    // follow from the slot count.
    localparam int MAXW_LOG = $clog2(MAX_WINDOW + 1) - 1;
    localparam int SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int STEP_W   = $clog2(MAX_WINDOW + 1);

    // Configuration registers.
    logic [2:0] window_bits_reg;
    logic [3:0] seq_bits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_bits_reg <= RST_WINDOW_BITS;
            seq_bits_reg    <= RST_SEQ_BITS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_WINDOW_BITS: window_bits_reg <= cfg_wdata[2:0];
                CFG_SEQ_BITS:    seq_bits_reg    <= cfg_wdata;
                default:         ;
            endcase
        end
    end

    // Effective sequence space and window. The window exponent is limited by
    // the slot store and by half the sequence space.
    logic [3:0]       sb_eff;
    logic [2:0]       sb_m1;
    logic [2:0]       wb_cap;
    logic [2:0]       wl_a;
    logic [2:0]       wl;
    logic [SEQ_W-1:0] smask;
    logic [SEQ_W-1:0] wmask;
    logic [6:0]       win;

    always_comb
    begin
        if (seq_bits_reg == 4'd0)
        begin
            sb_eff = 4'd1;
        end
        else if (seq_bits_reg > 4'(MAX_SEQ_BITS))
        begin
            sb_eff = 4'(MAX_SEQ_BITS);
        end
        else
        begin
            sb_eff = seq_bits_reg;
        end
        sb_m1  = 3'(sb_eff - 4'd1);
        wb_cap = (window_bits_reg > 3'(MAX_WIN_BITS)) ? 3'(MAX_WIN_BITS) : window_bits_reg;
        wl_a   = (wb_cap < 3'(MAXW_LOG)) ? wb_cap : 3'(MAXW_LOG);
        wl     = (wl_a < sb_m1) ? wl_a : sb_m1;
        smask  = 8'((9'd1 << sb_eff) - 9'd1);
        wmask  = 8'((8'd1 << wl) - 8'd1);
        win    = 7'(7'd1 << wl);
    end

    // Sequencer and item registers.
    state_t                state_reg;
    state_t                state_next;
    op_t                   op_reg;
    logic [DATA_W-1:0]     pay_reg;
    logic [SEQ_W-1:0]      sn_reg;
    logic                  csum_reg;
    logic [SEQ_W-1:0]      base_reg;
    logic [SEQ_W-1:0]      base_next;
    logic [SEQ_W-1:0]      next_reg;
    logic [SEQ_W-1:0]      next_next;
    logic [STEP_W-1:0]     steps_reg;
    logic [STEP_W-1:0]     steps_next;
    res_t                  res_reg;

    // Output register.
    logic                  m_tvalid_reg;
    res_t                  out_res_reg;
    logic [SEQ_W-1:0]      out_base_reg;
    logic [SEQ_W-1:0]      out_next_reg;
    logic                  out_full_reg;

    logic                  in_accept;
    logic                  out_free;
    logic                  out_load;

    // Execute-cycle results.
    logic [SEQ_W-1:0]      base_m;
    logic [SEQ_W-1:0]      next_m;
    logic                  full_pre;
    res_t                  res_c;
    logic                  has_result;
    logic                  slide_req;
    logic [SEQ_W-1:0]      next_new;
    logic [SEQ_W-1:0]      tmo_seq;

    // Memory and mark interface.
    logic [PAYLOAD_BITS-1:0] mem_wdata;
    logic [PAYLOAD_BITS-1:0] mem_rdata;
    logic                    mem_we;
    logic [SLOT_W-1:0]       mem_waddr;
    logic [SLOT_W-1:0]       mem_raddr;
    logic                    mark_set;
    logic [SLOT_W-1:0]       mark_set_idx;
    logic                    mark_clr;
    logic [SLOT_W-1:0]       mark_clr_idx;
    logic [SLOT_W-1:0]       mark_rd_idx;
    logic                    mark_bit;
    logic                    slide_go;

    // Final values loaded into the output register.
    res_t                  fin_res;
    logic [SEQ_W-1:0]      fin_base;
    logic [SEQ_W-1:0]      fin_next;
    logic [SEQ_W-1:0]      fin_diff;
    logic                  fin_full;

    assign in_accept = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign out_free  = !m_tvalid_reg || m_tready;

    // The timeout slot is read as the item is accepted; the data is ready in
    // the execute cycle. A send writes its slot only in the execute cycle, and
    // no new item is accepted before that write has landed.
    assign mem_raddr = SLOT_W'(s_tdata[39:32] & smask & wmask);
    assign mem_wdata = PAYLOAD_BITS'(64'(pay_reg));

    always_comb
    begin
        base_m     = base_reg & smask;
        next_m     = next_reg & smask;
        full_pre   = (8'((next_m - base_m) & smask) >= {1'b0, win});
        tmo_seq    = sn_reg & smask;
        next_new   = next_m;
        res_c      = '0;
        has_result = 1'b1;
        slide_req  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = SLOT_W'(next_m & wmask);
        mark_set   = 1'b0;
        mark_set_idx = SLOT_W'(sn_reg & wmask);

        case (op_reg)
            OP_SEND:
            begin
                if (full_pre)
                begin
                    res_c.event_res = EV_REFUSED;
                end
                else
                begin
                    mem_we             = (state_reg == ST_EXEC);
                    res_c.event_res    = EV_SENT;
                    res_c.tx_valid     = 1'b1;
                    res_c.tx_seq       = next_m;
                    res_c.tx_payload   = 32'(64'(mem_wdata));
                    res_c.timer_start  = 1'b1;
                    res_c.timer_seq    = next_m;
                    next_new           = 8'(next_m + 8'd1) & smask;
                end
            end
            OP_ACK:
            begin
                if (!csum_reg)
                begin
                    res_c.event_res = EV_CORRUPT;
                end
                else if (((sn_reg & ~smask) != 8'd0) ||
                         (8'((sn_reg - base_m) & smask) >= {1'b0, win}))
                begin
                    res_c.event_res = EV_OUTSIDE;
                end
                else
                begin
                    mark_set          = (state_reg == ST_EXEC);
                    res_c.event_res   = EV_ACKED;
                    res_c.timer_stop  = 1'b1;
                    res_c.timer_seq   = sn_reg;
                    slide_req         = (sn_reg == base_m);
                end
            end
            OP_TIMEOUT:
            begin
                res_c.event_res   = EV_RESENT;
                res_c.tx_valid    = 1'b1;
                res_c.tx_seq      = tmo_seq;
                res_c.tx_payload  = 32'(64'(mem_rdata));
                res_c.timer_start = 1'b1;
                res_c.timer_seq   = tmo_seq;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    // Slide: one acked slot is cleared per cycle, up to a full window.
    assign mark_rd_idx  = SLOT_W'(base_reg & wmask);
    assign slide_go     = (state_reg == ST_SLIDE) && (8'(steps_reg) < 8'(win)) && mark_bit;
    assign mark_clr     = slide_go || mem_we;
    assign mark_clr_idx = slide_go ? mark_rd_idx : mem_waddr;

    always_comb
    begin
        if (state_reg == ST_EXEC)
        begin
            fin_res  = res_c;
            fin_base = base_m;
            fin_next = next_new;
        end
        else
        begin
            fin_res  = res_reg;
            fin_base = base_reg;
            fin_next = next_reg;
        end
        fin_diff = 8'(fin_next - fin_base) & smask;
        fin_full = (fin_diff >= {1'b0, win});
    end

    // Next state, counters and the output load strobe.
    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        next_next  = next_reg;
        steps_next = steps_reg;
        out_load   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                steps_next = '0;
                if (!has_result)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    base_next = base_m;
                    next_next = next_new;
                    if (slide_req)
                    begin
                        state_next = ST_SLIDE;
                    end
                    else if (out_free)
                    begin
                        out_load   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_HOLD;
                    end
                end
            end
            ST_SLIDE:
            begin
                if (slide_go)
                begin
                    base_next  = 8'(base_reg + 8'd1) & smask;
                    steps_next = STEP_W'(steps_reg + 1'b1);
                end
                else if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            base_reg     <= '0;
            next_reg     <= '0;
            steps_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            base_reg  <= base_next;
            next_reg  <= next_next;
            steps_reg <= steps_next;
            if (out_load)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg   <= op_t'(s_tuser);
            pay_reg  <= s_tdata[31:0];
            sn_reg   <= s_tdata[39:32];
            csum_reg <= s_tdata[40];
        end
        if (state_reg == ST_EXEC)
        begin
            res_reg <= res_c;
        end
        if (out_load)
        begin
            out_res_reg  <= fin_res;
            out_base_reg <= fin_base;
            out_next_reg <= fin_next;
            out_full_reg <= fin_full;
        end
    end

    srsw_payload_mem #(
        .DEPTH  (MAX_WINDOW),
        .WIDTH  (PAYLOAD_BITS),
        .ADDR_W (SLOT_W)
    ) u_payload_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data (mem_wdata),
        .rd_en   (in_accept),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    srsw_ack_marks #(
        .DEPTH  (MAX_WINDOW),
        .ADDR_W (SLOT_W)
    ) u_ack_marks (
        .clk     (clk),
        .rst_n   (rst_n),
        .set_en  (mark_set),
        .set_idx (mark_set_idx),
        .clr_en  (mark_clr),
        .clr_idx (mark_clr_idx),
        .rd_idx  (mark_rd_idx),
        .rd_bit  (mark_bit)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_res_reg.event_res;
    assign m_tdata  = {4'b0000,
                       out_full_reg,
                       out_next_reg,
                       out_base_reg,
                       out_res_reg.timer_seq,
                       out_res_reg.timer_stop,
                       out_res_reg.timer_start,
                       out_res_reg.tx_payload,
                       out_res_reg.tx_seq,
                       out_res_reg.tx_valid};

`ifndef SYNTHESIS
    // An accepted transaction always goes to the execute cycle next.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> (state_reg == ST_EXEC))
        else $error("accepted transaction did not enter execute");

    // The result register is only loaded when it is empty or being drained.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!m_tvalid_reg || m_tready))
        else $error("result register overwritten");

    // The slide never walks further than one window.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SLIDE) |-> (8'(steps_reg) <= 8'(win)))
        else $error("window slide overran the window");

    // A packet leaves exactly for a send or a retransmission.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (out_res_reg.tx_valid ==
                      ((out_res_reg.event_res == EV_SENT) ||
                       (out_res_reg.event_res == EV_RESENT))))
        else $error("tx_valid disagrees with event");

    // A memory write and a mark set never come from the same item.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_we && mark_set))
        else $error("send and ack handled together");
`endif

endmodule

// ===== tb/sv/tb_selective_repeat_sender_window_unit.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the selective-repeat ARQ sender window unit.
// Needs srsw_pkg, srsw_payload_mem, srsw_ack_marks and selective_repeat_sender_window_unit.
// Directed script first, then randomized phases under a range of register settings.

module tb_selective_repeat_sender_window_unit
    import srsw_pkg::*;
();

    // Timing and run-length knobs.
    localparam int CLK_HALF     = 6;
    localparam int RST_CYCLES   = 3;
    // Longest execution is an ACK that slides over the whole window.
    // The settle wait also covers a command that produces no result and is still in flight.
    localparam int SETTLE       = 40;
    localparam int PHASE_ITEMS  = 152;
    localparam int HOLD_AT      = 900;
    localparam int HOLD_CYCLES  = 400;
    localparam int LIMIT_CYCLES = 400000;
    localparam int N_SETTINGS   = 12;
    localparam int N_ROWS       = 21;

    // One command as the sender side sees it.
    typedef struct packed {
        op_t               op;
        logic [DATA_W-1:0] data;
        logic [SEQ_W-1:0]  sn;
        logic              ok;
    } cmd_t;

    // One result transaction, field by field.
    typedef struct packed {
        event_t            ev;
        logic              txv;
        logic [SEQ_W-1:0]  tx_seq;
        logic [DATA_W-1:0] tx_data;
        logic              t_start;
        logic              t_stop;
        logic [SEQ_W-1:0]  t_seq;
        logic [SEQ_W-1:0]  base;
        logic [SEQ_W-1:0]  nxt;
        logic              full;
    } outcome_t;

    // A row of the directed script. Where pinned is set, the event and the window
    // status are typed in by hand and replace the predicted ones.
    typedef struct packed {
        cmd_t             cmd;
        logic             pinned;
        event_t           ev;
        logic [SEQ_W-1:0] base;
        logic [SEQ_W-1:0] nxt;
        logic             full;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // payload[31:0], seq_num[39:32], checksum_ok[40], zero pad
    logic [1:0]  s_tuser = '0;   // operation[1:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;        // tx_valid[0], tx_seq[8:1], tx_payload[40:9],
                                 // timer_start[41], timer_stop[42], timer_seq[50:43],
                                 // window_base[58:51], next_seq[66:59],
                                 // window_full[67], zero pad
    logic [2:0]  m_tuser;        // event_res[2:0]
    logic        cfg_wr_en = 1'b0;
    logic        cfg_addr = CFG_WINDOW_BITS;
    logic [3:0]  cfg_wdata = '0;

    selective_repeat_sender_window_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #CLK_HALF clk = 1'b1;
        #CLK_HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Window predictor: its own copy of the registers and of the window state.
    // ------------------------------------------------------------------
    logic [2:0]        win_bits_q = RST_WINDOW_BITS;
    logic [3:0]        seq_bits_q = RST_SEQ_BITS;
    int unsigned       base_q = 0;
    int unsigned       next_q = 0;
    bit                acked_q   [DEF_MAX_WINDOW];
    logic [DATA_W-1:0] store_q   [DEF_MAX_WINDOW];
    // Slots that a send has filled; a retransmit must never read any other slot.
    bit                written_q [DEF_MAX_WINDOW];

    // Expected results in order of acceptance.
    outcome_t    result_q [$];

    int unsigned accepted_cnt = 0;
    int unsigned results_seen = 0;
    int unsigned mismatch_cnt = 0;
    int unsigned cycle_cnt = 0;
    int unsigned ev_count [8];
    int unsigned burst_left = 0;
    bit          hold_done = 1'b0;

    // Sequence space: a register value of zero acts as one bit, anything above
    // eight acts as eight bits.
    function automatic int unsigned seq_space();
        int unsigned b;
        b = seq_bits_q;
        if (b < 1) b = 1;
        if (b > MAX_SEQ_BITS) b = MAX_SEQ_BITS;
        return 1 << b;
    endfunction

    // Window length: the programmed power of two, capped by the slot count and by
    // half the sequence space.
    function automatic int unsigned window_len(input int unsigned s);
        int unsigned b;
        int unsigned w;
        b = win_bits_q;
        if (b > MAX_WIN_BITS) b = MAX_WIN_BITS;
        w = 1 << b;
        while (w > DEF_MAX_WINDOW && w > 1) w >>= 1;
        while (w > s / 2 && w > 1) w >>= 1;
        return w;
    endfunction

    // Packets sent but not yet passed by the base.
    function automatic int unsigned in_flight();
        return (next_q - base_q) & (seq_space() - 1);
    endfunction

    // Advances the predicted window by one command. Returns 0 for a command that
    // produces no result.
    function automatic bit window_step(input cmd_t c, output outcome_t o);
        int unsigned s;
        int unsigned smask;
        int unsigned w;
        int unsigned wmask;
        int unsigned sn;
        int unsigned slot;
        int unsigned steps;
        o = '0;
        if (c.op == OP_UNUSED) return 1'b0;
        s = seq_space();
        smask = s - 1;
        w = window_len(s);
        wmask = w - 1;
        sn = c.sn;
        // A register change may have shrunk the sequence space under the counters.
        base_q &= smask;
        next_q &= smask;
        case (c.op)
            OP_SEND:
            begin
                if (((next_q - base_q) & smask) >= w) begin
                    o.ev = EV_REFUSED;
                end else begin
                    slot = next_q & wmask;
                    store_q[slot] = c.data;
                    written_q[slot] = 1'b1;
                    acked_q[slot] = 1'b0;
                    o.ev = EV_SENT;
                    o.txv = 1'b1;
                    o.tx_seq = SEQ_W'(next_q);
                    o.tx_data = c.data;
                    o.t_start = 1'b1;
                    o.t_seq = SEQ_W'(next_q);
                    next_q = (next_q + 1) & smask;
                end
            end
            OP_ACK:
            begin
                // A bad checksum wins over everything else and changes nothing.
                if (!c.ok) begin
                    o.ev = EV_CORRUPT;
                end else if (sn >= s || ((sn - base_q) & smask) >= w) begin
                    o.ev = EV_OUTSIDE;
                end else begin
                    acked_q[sn & wmask] = 1'b1;
                    if (sn == base_q) begin
                        steps = 0;
                        while (steps < w && acked_q[base_q & wmask]) begin
                            acked_q[base_q & wmask] = 1'b0;
                            base_q = (base_q + 1) & smask;
                            steps++;
                        end
                    end
                    o.ev = EV_ACKED;
                    o.t_stop = 1'b1;
                    o.t_seq = SEQ_W'(sn);
                end
            end
            default:
            begin
                // Timer expiry: resend whatever the slot holds, outstanding or not.
                sn = sn & smask;
                o.ev = EV_RESENT;
                o.txv = 1'b1;
                o.tx_seq = SEQ_W'(sn);
                o.tx_data = store_q[sn & wmask];
                o.t_start = 1'b1;
                o.t_seq = SEQ_W'(sn);
            end
        endcase
        o.base = SEQ_W'(base_q);
        o.nxt = SEQ_W'(next_q);
        o.full = ((next_q - base_q) & smask) >= w;
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus generation.
    // ------------------------------------------------------------------

    // Steers a timer expiry onto a slot that holds a payload. The bits above the
    // window index stay random, so the reduction modulo the sequence space is
    // still exercised. With no filled slot in reach, the command becomes a send.
    function automatic cmd_t aim_timeout(input cmd_t c);
        int unsigned w;
        int unsigned wmask;
        int unsigned first;
        int unsigned j;
        w = window_len(seq_space());
        wmask = w - 1;
        if (written_q[(c.sn & (seq_space() - 1)) & wmask]) return c;
        first = $urandom_range(0, w - 1);
        for (int k = 0; k < w; k++) begin
            j = (first + k) % w;
            if (written_q[j]) begin
                c.sn = (c.sn & ~SEQ_W'(wmask)) | SEQ_W'(j);
                return c;
            end
        end
        c.op = OP_SEND;
        return c;
    endfunction

    // Picks the next random command. Most traffic is protocol-shaped (sends, ACKs
    // of packets in flight, expiries of packets in flight); a small share is
    // unused operations and completely random commands.
    function automatic cmd_t next_command();
        cmd_t        c;
        int unsigned s;
        int unsigned smask;
        int unsigned w;
        int unsigned b;
        int unsigned outst;
        int unsigned pick;
        s = seq_space();
        smask = s - 1;
        w = window_len(s);
        b = base_q & smask;
        outst = in_flight();
        c.op = OP_SEND;
        c.data = $urandom();
        c.sn = SEQ_W'($urandom_range(0, 255));
        c.ok = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 4) begin
            c.op = OP_UNUSED;
        end else if (pick < 8) begin
            c.op = op_t'($urandom_range(0, 2));
        end else if (pick < 45) begin
            c.op = OP_SEND;
        end else if (pick < 82) begin
            c.op = OP_ACK;
            c.ok = ($urandom_range(0, 15) != 0);
            if (outst != 0 && outst <= w) begin
                if ($urandom_range(0, 4) < 2)
                    c.sn = SEQ_W'(b);
                else
                    c.sn = SEQ_W'((b + $urandom_range(0, outst - 1)) & smask);
            end else if (outst == 0) begin
                // Acking the base with nothing in flight pushes the base past next,
                // so that stays rare; mostly an empty window gets a send.
                if ($urandom_range(0, 7) == 0)
                    c.sn = SEQ_W'((b + $urandom_range(0, w - 1)) & smask);
                else
                    c.op = OP_SEND;
            end else begin
                // The base has run past next: walk it back round with ACKs.
                if ($urandom_range(0, 1) == 0)
                    c.sn = SEQ_W'(b);
                else
                    c.sn = SEQ_W'((b + $urandom_range(0, w - 1)) & smask);
            end
        end else begin
            c.op = OP_TIMEOUT;
            if (outst != 0 && outst <= w)
                c.sn = SEQ_W'(((b + $urandom_range(0, outst - 1)) & smask) | (c.sn & ~smask));
        end
        if (c.op == OP_TIMEOUT) c = aim_timeout(c);
        return c;
    endfunction

    // Offers one command, waits for the handshake and records what it should
    // produce. The sender works in bursts with random gaps in between.
    task automatic issue(input cmd_t c, input bit pinned, input event_t p_ev,
                         input logic [SEQ_W-1:0] p_base, input logic [SEQ_W-1:0] p_nxt,
                         input logic p_full);
        int unsigned gap;
        outcome_t    o;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser <= c.op;
        s_tdata <= {7'd0, c.ok, c.sn, c.data};
        do @(posedge clk); while (!s_tready);
        accepted_cnt++;
        if (window_step(c, o)) begin
            if (pinned) begin
                o.ev = p_ev;
                o.base = p_base;
                o.nxt = p_nxt;
                o.full = p_full;
            end
            result_q.push_back(o);
        end
    endtask

    // Waits until every expected result has come back, then lets the pipeline
    // run dry in case the last command was one that produces no result.
    task automatic settle();
        while (result_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Directed script, run under the reset settings (window 4, 256 sequences).
    // It walks the window through a corrupt ACK, an out-of-range ACK, filling up
    // to a refused send, retransmits including a sequence far outside the window,
    // ACKs out of order, a slide over several acked slots and an ACK of a
    // sequence that has not gone out yet.
    // ------------------------------------------------------------------
    row_t script [N_ROWS] = '{
        '{'{OP_ACK,     32'h0000_0000, 8'd0,   1'b0}, 1'b1, EV_CORRUPT, 8'd0, 8'd0, 1'b0},
        '{'{OP_ACK,     32'h0000_0000, 8'd255, 1'b1}, 1'b1, EV_OUTSIDE, 8'd0, 8'd0, 1'b0},
        '{'{OP_UNUSED,  32'hFFFF_FFFF, 8'd255, 1'b1}, 1'b0, EV_REFUSED, 8'd0, 8'd0, 1'b0},
        '{'{OP_SEND,    32'hFFFF_FFFF, 8'd0,   1'b0}, 1'b1, EV_SENT,    8'd0, 8'd1, 1'b0},
        '{'{OP_SEND,    32'h0000_0000, 8'd0,   1'b1}, 1'b1, EV_SENT,    8'd0, 8'd2, 1'b0},
        '{'{OP_SEND,    32'hA5A5_A5A5, 8'd0,   1'b0}, 1'b0, EV_REFUSED, 8'd0, 8'd0, 1'b0},
        '{'{OP_SEND,    32'h5A5A_5A5A, 8'd0,   1'b0}, 1'b1, EV_SENT,    8'd0, 8'd4, 1'b1},
        '{'{OP_SEND,    32'h1357_9BDF, 8'd0,   1'b0}, 1'b1, EV_REFUSED, 8'd0, 8'd4, 1'b1},
        '{'{OP_TIMEOUT, 32'h0000_0000, 8'd2,   1'b0}, 1'b0, EV_REFUSED, 8'd0, 8'd0, 1'b0},
        '{'{OP_TIMEOUT, 32'h0000_0000, 8'd255, 1'b1}, 1'b0, EV_REFUSED, 8'd0, 8'd0, 1'b0},
        '{'{OP_ACK,     32'h0000_0000, 8'd2,   1'b1}, 1'b0, EV_REFUSED, 8'd0, 8'd0, 1'b0},
        '{'{OP_ACK,     32'h0000_0000, 8'd5,   1'b1}, 1'b1, EV_OUTSIDE, 8'd0, 8'd4, 1'b1},
        '{'{OP_ACK,     32'h0000_0000, 8'd3,   1'b1}, 1'b0, EV_REFUSED, 8'd0, 8'd0, 1'b0},
        '{'{OP_ACK,     32'h0000_0000, 8'd0,   1'b1}, 1'b0, EV_REFUSED, 8'd0, 8'd0, 1'b0},
        '{'{OP_ACK,     32'h0000_0000, 8'd1,   1'b1}, 1'b0, EV_REFUSED, 8'd0, 8'd0, 1'b0},
        '{'{OP_ACK,     32'h0000_0000, 8'd6,   1'b1}, 1'b0, EV_REFUSED, 8'd0, 8'd0, 1'b0},
        '{'{OP_SEND,    32'h1234_5678, 8'd0,   1'b0}, 1'b0, EV_REFUSED, 8'd0, 8'd0, 1'b0},
        '{'{OP_SEND,    32'h8765_4321, 8'd0,   1'b1}, 1'b0, EV_REFUSED, 8'd0, 8'd0, 1'b0},
        '{'{OP_ACK,     32'h0000_0000, 8'd4,   1'b1}, 1'b0, EV_REFUSED, 8'd0, 8'd0, 1'b0},
        '{'{OP_ACK,     32'h0000_0000, 8'd0,   1'b0}, 1'b1, EV_CORRUPT, 8'd5, 8'd6, 1'b0},
        '{'{OP_TIMEOUT, 32'h0000_0000, 8'd5,   1'b0}, 1'b0, EV_REFUSED, 8'd0, 8'd0, 1'b0}
    };

    // Register settings of the random phases: {window_bits, seq_bits} with the
    // extremes of both registers, out-of-range values that must saturate, and
    // windows clipped by a small sequence space. The wind-down flag acks all
    // packets in flight before the next setting; one phase skips it so that a
    // change of setting lands on an odd base/next pair.
    logic [2:0] set_wb   [N_SETTINGS] = '{3'd0, 3'd4, 3'd7, 3'd1, 3'd3, 3'd5,
                                          3'd2, 3'd4, 3'd6, 3'd0, 3'd4, 3'd3};
    logic [3:0] set_sb   [N_SETTINGS] = '{4'd1, 4'd8, 4'd15, 4'd0, 4'd3, 4'd9,
                                          4'd4, 4'd2, 4'd6, 4'd8, 4'd5, 4'd8};
    bit         set_wind [N_SETTINGS] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1,
                                          1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1};

    // ------------------------------------------------------------------
    // Result checking. Outputs are sampled right after the edge, so the values
    // seen are the ones the block presented at that edge.
    // ------------------------------------------------------------------
    function automatic void check_field(input string name, input logic [DATA_W-1:0] want,
                                        input logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge clk)
    begin : result_check
        outcome_t want;
        outcome_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got = {event_t'(m_tuser), m_tdata[0], m_tdata[8:1], m_tdata[40:9],
                   m_tdata[41], m_tdata[42], m_tdata[50:43], m_tdata[58:51],
                   m_tdata[66:59], m_tdata[67]};
            results_seen++;
            ev_count[m_tuser]++;
            if (result_q.size() == 0) begin
                $error("result transaction with nothing expected: event_res %0d", m_tuser);
                mismatch_cnt++;
            end else begin
                want = result_q.pop_front();
                check_field("event_res", want.ev, got.ev);
                check_field("tx_valid", want.txv, got.txv);
                check_field("tx_seq", want.tx_seq, got.tx_seq);
                check_field("tx_payload", want.tx_data, got.tx_data);
                check_field("timer_start", want.t_start, got.t_start);
                check_field("timer_stop", want.t_stop, got.t_stop);
                check_field("timer_seq", want.t_seq, got.t_seq);
                check_field("window_base", want.base, got.base);
                check_field("next_seq", want.nxt, got.nxt);
                check_field("window_full", want.full, got.full);
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver side. It changes its manner every so often: always ready, ready at
    // random, or ready on a fixed rhythm. Once, partway through the run, it holds
    // off for a long stretch while the sender keeps offering, so that the result
    // register and the execution stage fill up and s_tready drops.
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int unsigned mode;
        int unsigned left;
        int unsigned tick;
        mode = 0;
        left = 0;
        tick = 0;
        forever begin
            @(posedge clk);
            if (!hold_done && accepted_cnt >= HOLD_AT) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 2);
                left = $urandom_range(32, 200);
            end
            left--;
            tick++;
            case (mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= (tick % 5) >= 2;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Run limit. The slowest correct run stays far below this count.
    // ------------------------------------------------------------------
    always @(posedge clk) cycle_cnt <= cycle_cnt + 1;

    initial
    begin : watchdog
        while (cycle_cnt < LIMIT_CYCLES) @(posedge clk);
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence: reset, directed script, then one random phase per setting.
    // Registers change only after every expected result is back and the block
    // has had time to finish a command that produces no result.
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        cmd_t        c;
        int unsigned n;
        repeat (RST_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
            issue(script[i].cmd, script[i].pinned, script[i].ev, script[i].base,
                  script[i].nxt, script[i].full);
        s_tvalid <= 1'b0;
        settle();

        for (int p = 0; p < N_SETTINGS; p++) begin
            cfg_wr_en <= 1'b1;
            cfg_addr <= CFG_WINDOW_BITS;
            cfg_wdata <= {1'b0, set_wb[p]};
            @(posedge clk);
            cfg_addr <= CFG_SEQ_BITS;
            cfg_wdata <= set_sb[p];
            @(posedge clk);
            cfg_wr_en <= 1'b0;
            win_bits_q = set_wb[p];
            seq_bits_q = set_sb[p];

            // Unused operations pass through without counting toward the phase.
            n = 0;
            while (n < PHASE_ITEMS) begin
                c = next_command();
                issue(c, 1'b0, EV_REFUSED, '0, '0, 1'b0);
                if (c.op != OP_UNUSED) n++;
            end

            // Ack the base until nothing is in flight; each such ACK slides it.
            if (set_wind[p]) begin
                while (in_flight() != 0 && in_flight() <= window_len(seq_space())) begin
                    c = '{OP_ACK, DATA_W'($urandom()), SEQ_W'(base_q), 1'b1};
                    issue(c, 1'b0, EV_REFUSED, '0, '0, 1'b0);
                end
            end
            s_tvalid <= 1'b0;
            settle();
        end

        $display("Run covered %0d commands under %0d register settings; %0d results checked.",
                 accepted_cnt, N_SETTINGS + 1, results_seen);
        $display("Results: sent %0d, refused %0d, acked %0d, outside %0d, corrupt %0d, resent %0d.",
                 ev_count[EV_SENT], ev_count[EV_REFUSED], ev_count[EV_ACKED],
                 ev_count[EV_OUTSIDE], ev_count[EV_CORRUPT], ev_count[EV_RESENT]);
        if (mismatch_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
